// File: hw/rtl/md5_pkg.sv
// Shared constants, tables and helper functions for the MD5 stream hasher.
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned ROUNDS          = 64;
    localparam logic [7:0]  PAD_BYTE        = 8'h80;
    localparam logic [5:0]  LEN_OFFSET      = 6'd56;
    localparam logic [2:0]  MAX_BYTES       = 3'd4;

    typedef logic [31:0] t_word;

    function automatic t_word round_const(input logic [5:0] r);
        t_word k;
        case (r)
            6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB; 6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8; 6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/md5_round.sv
// MD5 compression engine: one round per cycle over a 16-word block memory.
module md5_round
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [3:0]  i_wr_addr,
    input  t_word       i_wr_data,
    input  logic        i_start,
    input  logic        i_init,
    output logic        o_busy,
    output t_word       o_chain [4]
);

    t_word      r_mem [WORDS_PER_BLOCK];
    t_word      r_msg;
    t_word      r_chain [4];
    t_word      r_a, r_b, r_c, r_d;
    logic [5:0] r_round;
    logic       r_run;
    logic       r_fin;

    // message word index for a round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0:    g = r[3:0];
            2'd1:    g = 4'(5 * r[3:0] + 1);
            2'd2:    g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

    t_word      f, sum, rot;
    logic [4:0] s;
    logic [5:0] n_round;

    always_comb begin
        case (r_round[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + round_const(r_round) + r_msg;
        s   = rot_amount({r_round[5:4], r_round[1:0]});
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
        n_round = r_run ? r_round + 6'd1 : 6'd0;
    end

    // block memory; message word prefetched for the next round
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_msg <= r_mem[msg_index(n_round)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
            r_chain <= '{INIT_A, INIT_B, INIT_C, INIT_D};
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_init) begin
                r_chain <= '{INIT_A, INIT_B, INIT_C, INIT_D};
            end
            if (i_start) begin
                r_run   <= 1'b1;
                r_round <= '0;
                r_a <= r_chain[0]; r_b <= r_chain[1];
                r_c <= r_chain[2]; r_d <= r_chain[3];
            end else if (r_run) begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + rot;
                r_round <= n_round;
                if (r_round == 6'(ROUNDS - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
        end
    end

    assign o_busy  = r_run | r_fin;
    assign o_chain = r_chain;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_start) else $error("start while compressing");
    a_fin_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_run)) else $error("finish without run");
    a_no_init_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run || r_fin) |-> !i_init) else $error("init during compression");

endmodule

// File: hw/rtl/md5_hash_stream.sv
// Top level of the MD5 stream hasher: byte packing, padding and digest output.
// Computes the MD5 digest of a byte message arriving as little-endian 32-bit
// words, up to four bytes each, first byte in bits 7:0 (byte_count values above
// four act as four). The block is sequential: o_stall is high from the
// accepting edge until the item is fully packed, and after a last word until
// the digest has been offered. The packer takes one byte per cycle while the
// round unit is not busy: an item is accepted, its bytes are packed and a
// closing step returns to idle, or starts padding after a last word. Each
// completed 64-byte block runs the round unit, one round per cycle, and the
// packer waits while it runs the 64 rounds and adds the result into the chain.
// On a word with last_word set the block appends 0x80, zero fill and the
// 64-bit bit length one byte per cycle while the round unit is not busy (9 to
// 72 bytes, with one or two compressions), then offers digest words A..D with
// index 0..3 and digest_last on D, one per cycle once the final compression
// is done and the receiver does not stall, then awaits the next message.
module md5_hash_stream
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_digest_index,
    output logic        o_digest_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_BYTES, S_PAD, S_LEN, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_data;
    logic [2:0]  r_left;
    logic [1:0]  r_pos;
    logic        r_last;
    logic [60:0] r_total;
    logic [63:0] r_bits;
    logic [31:0] r_part;
    logic [1:0]  r_pbytes;
    logic [3:0]  r_fill;
    logic [2:0]  r_lenk;
    logic [1:0]  r_oidx;
    logic        r_init;

    logic        busy;
    t_word       chain [4];

    logic        put;
    logic [7:0]  put_byte;
    logic        wr_en;
    t_word       wr_data;
    logic        start;
    logic [5:0]  fill_bytes;

    assign fill_bytes = {r_fill, r_pbytes};

    // byte packer: a full word goes to the engine memory, 16 words start it
    always_comb begin
        put      = 1'b0;
        put_byte = 8'h00;
        if (!busy) begin
            case (r_state)
                S_BYTES: begin
                    put      = (r_left != 3'd0);
                    put_byte = r_data[8*r_pos +: 8];
                end
                S_PAD: begin
                    put      = 1'b1;
                    put_byte = (r_left != 3'd0) ? PAD_BYTE : 8'h00;
                end
                S_LEN: begin
                    put      = 1'b1;
                    put_byte = r_bits[8*r_lenk +: 8];
                end
                default: ;
            endcase
        end
        wr_data = r_part | (32'(put_byte) << (8 * r_pbytes));
        wr_en   = put && (r_pbytes == 2'd3);
        start   = wr_en && (r_fill == 4'd15);
    end

    md5_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (wr_data),
        .i_start   (start),
        .i_init    (r_init),
        .o_busy    (busy),
        .o_chain   (chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_part   <= '0;
            r_pbytes <= '0;
            r_fill   <= '0;
            r_oidx   <= '0;
            r_init   <= 1'b0;
            r_left   <= '0;
            r_pos    <= '0;
            r_lenk   <= '0;
            r_last   <= 1'b0;
        end else begin
            r_init <= 1'b0;
            if (put) begin
                if (r_pbytes == 2'd3) begin
                    r_part <= '0;
                    r_fill <= r_fill + 4'd1;
                end else begin
                    r_part <= wr_data;
                end
                r_pbytes <= r_pbytes + 2'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data  <= i_data_word;
                        r_left  <= (i_byte_count > MAX_BYTES) ? MAX_BYTES : i_byte_count;
                        r_pos   <= '0;
                        r_last  <= i_last_word;
                        r_state <= S_BYTES;
                    end
                end
                S_BYTES: begin
                    if (!busy) begin
                        if (r_left != 3'd0) begin
                            r_left  <= r_left - 3'd1;
                            r_pos   <= r_pos + 2'd1;
                            r_total <= r_total + 61'd1;
                        end else if (r_last) begin
                            r_bits  <= {r_total, 3'b000};
                            r_left  <= 3'd1;
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    if (!busy) begin
                        r_left <= '0;
                        if (fill_bytes + 6'd1 == LEN_OFFSET) begin
                            r_lenk  <= '0;
                            r_state <= S_LEN;
                        end
                    end
                end
                S_LEN: begin
                    if (!busy) begin
                        r_lenk <= r_lenk + 3'd1;
                        if (r_lenk == 3'd7) begin
                            r_oidx  <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!busy && !i_stall) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_init  <= 1'b1;
                            r_total <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT) && !busy;
    assign o_digest_word  = chain[r_oidx];
    assign o_digest_index = r_oidx;
    assign o_digest_last  = (r_oidx == 2'd3);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_digest_index))
        else $error("digest dropped under stall");
    a_no_put_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !put) else $error("byte packed while compressing");
    a_out_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_fill == 4'd0) && (r_pbytes == 2'd0))
        else $error("digest with partial block");

endmodule

// File: tb/sv/tb_md5_hash_stream.sv
// Testbench for the MD5 stream hasher: directed and random messages checked against a digest model.
`timescale 1ns / 100ps

module tb_md5_hash_stream
    import md5_pkg::*;
();

    localparam int unsigned MAX_CYCLES = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last_word = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_digest_index;
    logic        o_digest_last;

    md5_hash_stream i_dut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
        bit          typed;     // expected digest typed in the table
        logic [127:0] digest;   // A,B,C,D from high to low
    } t_stim;

    // Digest model state
    logic [31:0] hash_chain[4];
    logic [31:0] msg_block[16];
    logic [60:0] msg_bytes;
    logic [31:0] pack_word;
    int unsigned pack_bytes;
    int unsigned block_words;

    t_digest     digest_q[$];
    t_stim       stim_q[$];
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          calm = 1'b0;

    // MD5 round constants and rotate amounts
    localparam logic [31:0] K_TAB[64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
    localparam int unsigned S_TAB[16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                         4, 11, 16, 23, 6, 10, 15, 21};

    task automatic chain_start();
        hash_chain[0] = INIT_A; hash_chain[1] = INIT_B;
        hash_chain[2] = INIT_C; hash_chain[3] = INIT_D;
        msg_bytes = '0; pack_word = '0; pack_bytes = 0; block_words = 0;
    endtask

    task automatic compress_block();
        logic [31:0] a, b, c, d, f, t;
        int unsigned g, ph;
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        for (int r = 0; r < 64; r++) begin
            ph = r / 16;
            case (ph)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            t = a + f + K_TAB[r] + msg_block[g];
            a = d; d = c; c = b;
            b = b + ((t << S_TAB[ph * 4 + r % 4]) | (t >> (32 - S_TAB[ph * 4 + r % 4])));
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    endtask

    task automatic pack_byte(input logic [7:0] v);
        pack_word |= 32'(v) << (pack_bytes * 8);
        pack_bytes++;
        if (pack_bytes == 4) begin
            msg_block[block_words] = pack_word;
            pack_word = '0; pack_bytes = 0; block_words++;
            if (block_words == 16) begin
                compress_block();
                block_words = 0;
            end
        end
    endtask

    // Feeds one accepted item; queues four digest words on a last word.
    task automatic digest_predict(input logic [31:0] data, input logic [2:0] cnt,
                                  input logic last);
        int unsigned n;
        logic [63:0] bits;
        n = (cnt > 4) ? 4 : cnt;
        for (int k = 0; k < n; k++) begin
            pack_byte(data[8 * k +: 8]);
            msg_bytes++;
        end
        if (last) begin
            bits = {msg_bytes, 3'b000};
            pack_byte(PAD_BYTE);
            while (block_words * 4 + pack_bytes != 56) pack_byte(8'h00);
            for (int k = 0; k < 8; k++) pack_byte(bits[8 * k +: 8]);
            for (int k = 0; k < 4; k++)
                digest_q.push_back('{hash_chain[k], 2'(k), k == 3});
            chain_start();
        end
    endtask

    task automatic add_item(input logic [31:0] d, input logic [2:0] c, input logic l);
        stim_q.push_back('{d, c, l, 1'b0, '0});
    endtask

    task automatic add_message(input int unsigned nbytes);
        int unsigned left;
        left = nbytes;
        while (left > 4) begin
            add_item($urandom, 3'd4, 1'b0);
            left -= 4;
        end
        add_item($urandom, 3'(left), 1'b1);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("FAIL md5_hash_stream");
            $finish;
        end
    end

    // Receiver: random stall, plus one long hold-off to back the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= hold_off || (!calm && $urandom_range(99) < 38);
    end

    initial begin
        wait (i_rst_n);
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Checker
    always @(posedge i_clk) begin
        t_digest got, exp;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_digest_word, o_digest_index, o_digest_last};
            if (digest_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected digest word %h", got);
            end else begin
                exp = digest_q.pop_front();
                if (got !== exp) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp.word, exp.index, exp.last,
                                 got.word, got.index, got.last);
                end
            end
        end
    end

    initial begin
        t_stim s;
        int unsigned idx;
        chain_start();
        // Directed table: empty message and "abc" have known digests.
        stim_q.push_back('{32'h0, 3'd0, 1'b1, 1'b1,
                           128'hd98c1dd404b2008f980980e97e42f8ec});
        stim_q.push_back('{32'h00636261, 3'd3, 1'b1, 1'b1,
                           128'h98500190b04fd23c7d3f96d6727fe128});
        add_item(32'hFFFFFFFF, 3'd7, 1'b0);        // count above four acts as four
        add_item(32'hFFFFFFFF, 3'd0, 1'b0);        // no bytes taken
        add_item(32'h00000000, 3'd5, 1'b0);
        add_item(32'hA5A5A5A5, 3'd1, 1'b0);        // short word, next bytes follow
        add_item(32'h5A5A5A5A, 3'd2, 1'b0);
        add_item(32'h12345678, 3'd6, 1'b1);
        for (int i = 0; i < 13; i++) add_item($urandom, 3'd4, 1'b0);
        add_item($urandom, 3'd3, 1'b1);            // 55 bytes: fits one block
        for (int i = 0; i < 14; i++) add_item($urandom, 3'd4, 1'b0);
        add_item(32'hFFFFFFFF, 3'd0, 1'b1);        // 56 bytes: extra pad block

        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (idx < 160) begin
            if (idx >= stim_q.size()) begin
                // Random part: mostly well-formed messages, some noisy words.
                if ($urandom_range(9) == 0)
                    add_item($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)));
                else if ($urandom_range(5) == 0)
                    add_message($urandom_range(70, 140));
                else
                    add_message($urandom_range(0, 40));
            end
            if (idx >= stim_q.size()) continue;
            s = stim_q[idx];
            calm = (idx >= 60 && idx < 110);
            if (!calm) begin
                while ($urandom_range(99) < 38) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_valid <= 1'b1;
            i_data_word <= s.data;
            i_byte_count <= s.count;
            i_last_word <= s.last;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            if (s.typed) begin
                for (int k = 0; k < 4; k++)
                    digest_q.push_back('{s.digest[127 - 32 * k -: 32], 2'(k), k == 3});
                chain_start();
            end else begin
                digest_predict(s.data, s.count, s.last);
            end
            idx++;
        end
        // Close any message left open by noise so all results drain.
        i_valid <= 1'b1;
        i_data_word <= $urandom;
        i_byte_count <= 3'd0;
        i_last_word <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        digest_predict(32'h0, 3'd0, 1'b1);
        i_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS md5_hash_stream");
        else
            $display("FAIL md5_hash_stream");
        $finish;
    end

endmodule

// File: md5_hash_stream.f
hw/rtl/md5_pkg.sv
hw/rtl/md5_round.sv
hw/rtl/md5_hash_stream.sv
tb/sv/tb_md5_hash_stream.sv
